// File: rtl/murmur2_hash_stream_assert.svh
// Assertion macros for the MurmurHash2 stream block.
// Included by modules that check their own control logic; no other dependencies.
`ifndef MURMUR2_HASH_STREAM_ASSERT_SVH
`define MURMUR2_HASH_STREAM_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MH2_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mh2 check failed");

// antecedent implies consequent in the next cycle
`define MH2_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mh2 check failed");

`endif

// File: rtl/mh2_pkg.sv
// Shared types and constants for the MurmurHash2 stream block.
// No dependencies; imported by controller, datapath and top level.
`default_nettype none

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 3;
    localparam int KLEN_W  = 32;
    localparam int TDATA_W = 72;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_KMIX1,
        OP_KMIX2,
        OP_FOLD,
        OP_TAIL,
        OP_FIN
    } mh2_op_t;

    typedef struct packed {
        mh2_op_t op;
        logic    out_load;
    } mh2_cmd_t;

    typedef struct packed {
        logic last;
        logic full;
        logic zero;
    } mh2_status_t;

endpackage

`default_nettype wire

// File: rtl/mh2_datapath.sv
// Datapath: seed, accumulator, key-word register and one shared 32x32 multiplier.
// Depends on mh2_pkg; driven by mh2_ctrl through mh2_cmd_t.
`default_nettype none

module mh2_datapath
    import mh2_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic [DATA_W-1:0]   data_word,
    input  wire logic [COUNT_W-1:0]  byte_count,
    input  wire logic                first_item,
    input  wire logic                last_item,
    input  wire logic [KLEN_W-1:0]   key_length,
    input  wire mh2_cmd_t            cmd,
    output mh2_status_t              status,
    output logic [31:0]              hash_value
);

    logic [31:0]        seed_reg;
    logic [31:0]        h_reg, h_next;
    logic [31:0]        k_reg, k_next;
    logic [31:0]        word_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               last_reg;
    logic [31:0]        hash_reg;
    logic [31:0]        tail_mask;
    logic [31:0]        mul_a;
    logic [31:0]        prod;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_KMIX1: mul_a = k_reg;
            OP_KMIX2: mul_a = k_reg;
            OP_FOLD:  mul_a = h_reg;
            OP_TAIL:  mul_a = h_reg ^ (word_reg & tail_mask);
            OP_FIN:   mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default:  mul_a = k_reg;
        endcase
    end

    assign prod = 32'(mul_a * MIX_MUL);

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                h_next = first_item ? (seed_reg ^ key_length) : h_reg;
                k_next = data_word;
            end
            OP_KMIX1: k_next = prod ^ (prod >> MIX_SHIFT);
            OP_KMIX2: k_next = prod;
            OP_FOLD:  h_next = prod ^ k_reg;
            OP_TAIL:  h_next = prod;
            OP_FIN:   h_next = prod ^ (prod >> FIN_SHIFT_B);
            default:
            begin
                h_next = h_reg;
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            h_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            h_reg <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.op == OP_LOAD)
        begin
            word_reg <= data_word;
            cnt_reg  <= byte_count;
            last_reg <= last_item;
        end
        if (cmd.out_load)
        begin
            hash_reg <= h_reg;
        end
    end

    assign status.last = last_reg;
    assign status.full = cnt_reg[2];
    assign status.zero = (cnt_reg == '0);
    assign hash_value  = hash_reg;

endmodule

`default_nettype wire

// File: rtl/mh2_ctrl.sv
// Controller: sequences load, word mix, fold, tail and avalanche steps; owns handshakes.
// Depends on mh2_pkg and murmur2_hash_stream_assert.svh.
`default_nettype none

`include "murmur2_hash_stream_assert.svh"

module mh2_ctrl
    import mh2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire mh2_status_t status,
    output mh2_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_FOLD,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MIX1;
                end
            end
            S_MIX1:
            begin
                if (!status.last || status.full)
                begin
                    cmd.op     = OP_KMIX1;
                    state_next = S_MIX2;
                end
                else if (!status.zero)
                begin
                    cmd.op     = OP_TAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_OUT;
                end
            end
            S_MIX2:
            begin
                cmd.op     = OP_KMIX2;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.op     = OP_FOLD;
                state_next = status.last ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `MH2_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, (!m_valid_reg || m_ready))
    `MH2_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !s_ready)
    `MH2_ASSERT_IMPL(a_result_from_out, clk, rst_n, $rose(m_valid_reg), $past(state_reg == S_OUT))

endmodule

`default_nettype wire

// File: rtl/murmur2_hash_stream.sv
// Steps: a last full-word item runs MIX1, MIX2, FOLD, FIN, OUT; a 1-3 byte tail runs
// MIX1 (tail mix), FIN, OUT; an empty tail runs MIX1 (final mix), OUT; OUT waits for a free
// output and sets m_axis_tvalid. A non-last word runs MIX1, MIX2, FOLD (three multiplies on
// one shared multiplier); one item in flight, so the input is not ready until IDLE again.
// Reset (rst_n, async low) clears seed, accumulator, state and output valid.
// Depends on mh2_pkg, mh2_ctrl and mh2_datapath.
`default_nettype none

module murmur2_hash_stream
    import mh2_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,      // seed
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32],
                                                    // key_length[66:35], zero pad
    input  wire logic               s_axis_tuser,   // first_item
    input  wire logic               s_axis_tlast,   // last_item
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [31:0]             m_axis_tdata    // hash_value
);

    mh2_cmd_t    cmd;
    mh2_status_t status;

    mh2_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mh2_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .data_word  (s_axis_tdata[31:0]),
        .byte_count (s_axis_tdata[34:32]),
        .first_item (s_axis_tuser),
        .last_item  (s_axis_tlast),
        .key_length (s_axis_tdata[66:35]),
        .cmd        (cmd),
        .status     (status),
        .hash_value (m_axis_tdata)
    );

endmodule

`default_nettype wire
